/* src/sbf_pkg.sv */
// Shared types, constants and helpers for the store buffer forwarding core.
// Used by sbf_alu and tso_store_buffer_forwarding_core; depends on nothing.
package sbf_pkg;

  localparam int CORES       = 4;
  localparam int DEPTH       = 8;
  localparam int CORE_W      = 2;
  localparam int IDX_W       = 3;
  localparam int CNT_W       = 4;
  localparam int SLOT_W      = CORE_W + IDX_W;
  localparam int SLOTS       = CORES * DEPTH;
  localparam int IN_TDATA_W  = 264;
  localparam int OUT_TDATA_W = 200;

  typedef enum logic [2:0] {
    K_STORE        = 3'd0,
    K_LOAD         = 3'd1,
    K_DRAIN_OLDEST = 3'd2,
    K_DRAIN_CORE   = 3'd3,
    K_DRAIN_ALL    = 3'd4,
    K_FENCE        = 3'd5,
    K_CAS          = 3'd6,
    K_FADD         = 3'd7
  } kind_t;

  typedef enum logic [2:0] {
    RK_WRITE = 3'd0,
    RK_LOAD  = 3'd1,
    RK_XCHG  = 3'd2,
    RK_FADD  = 3'd3,
    RK_DONE  = 3'd4,
    RK_ERROR = 3'd5
  } rkind_t;

  typedef struct packed {
    logic [63:0] tag;
    logic [63:0] value;
    logic [1:0]  size;
    logic [63:0] addr;
  } entry_t;

  // Partially merged load value and the bytes already taken from younger stores.
  typedef struct packed {
    logic [63:0] mval;
    logic [7:0]  claim;
  } merge_t;

  function automatic logic [63:0] size_mask(input logic [1:0] sc);
    logic [63:0] m;
    case (sc)
      2'd0:    m = 64'h0000_0000_0000_00FF;
      2'd1:    m = 64'h0000_0000_0000_FFFF;
      2'd2:    m = 64'h0000_0000_FFFF_FFFF;
      default: m = 64'hFFFF_FFFF_FFFF_FFFF;
    endcase
    return m;
  endfunction

  function automatic logic [3:0] nbytes(input logic [1:0] sc);
    return 4'd1 << sc;
  endfunction

endpackage

/* src/sbf_alu.sv */
// Shared compare and byte-merge unit: one 65-bit subtractor serves tag ordering
// and store-to-load address matching. Depends on sbf_pkg.
module sbf_alu (
  input  logic [63:0]    op_a,
  input  logic [63:0]    op_b,
  input  logic [1:0]     sc,
  input  logic [1:0]     e_size,
  input  logic [63:0]    e_value,
  input  sbf_pkg::merge_t cur,
  output logic           lt,
  output sbf_pkg::merge_t nxt
);
  import sbf_pkg::*;

  logic [64:0] diff;
  logic        pz, pn, pw, a_top;
  logic [3:0]  lane_sum [8];
  logic [7:0]  wrap, hit;
  logic [4:0]  dv [8];
  logic [4:0]  x  [8];

  assign diff  = {1'b0, op_a} - {1'b0, op_b};
  assign lt    = diff[64];
  assign pz    = (diff[64:3] == '0);
  assign pn    = (diff[64:3] == '1);
  assign pw    = (diff[64:3] == {1'b0, {61{1'b1}}});
  assign a_top = &op_a[63:3];

  // Each load byte checks whether it falls inside the entry; a byte whose
  // address wraps past the top of the space needs the entry near the top.
  always_comb begin
    nxt = cur;
    for (int b = 0; b < 8; b++) begin
      lane_sum[b] = {1'b0, op_a[2:0]} + 4'(b);
      wrap[b]     = a_top && lane_sum[b][3];
      dv[b]       = (pz && !wrap[b]) ? {2'b00, diff[2:0]} : {2'b11, diff[2:0]};
      x[b]        = dv[b] + 5'(b);
      hit[b]      = (wrap[b] ? pw : (pz || pn)) && !x[b][4] &&
                    (x[b][3:0] < nbytes(e_size));
      if ((4'(b) < nbytes(sc)) && hit[b] && !cur.claim[b]) begin
        nxt.mval[8*b +: 8] = e_value[{x[b][2:0], 3'b000} +: 8];
        nxt.claim[b]       = 1'b1;
      end
    end
  end

endmodule

/* src/tso_store_buffer_forwarding_core.sv */
// Per-core store buffers with store-to-load forwarding and ordered drains.
// Stores and errors answer straight from decode; a load first reads every entry of its core.
// Each drained entry is read and then sent out; age-ordered drains scan every core's head first.
// One request at a time; the entry memory's single registered read port sets the pace.
// Reset empties every queue, clears the tag counter and sets the core count to 4;
// buffer contents are not cleared. Depends on sbf_pkg and sbf_alu.
module tso_store_buffer_forwarding_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // core[1:0], address[65:2], size_code[67:66], operand_value[131:68],
  // expected_value[195:132], memory_value[259:196], zero pad
  input  logic [sbf_pkg::IN_TDATA_W-1:0]     in_tdata,
  // kind[2:0]
  input  logic [2:0]                         in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // out_address[63:0], out_size_code[65:64], data[129:66], sum_value[193:130],
  // flag[194], zero pad
  output logic [sbf_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // result_kind[2:0]
  output logic [2:0]                         out_tuser,
  output logic                               out_tlast,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [2:0]                         cfg_data
);
  import sbf_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DECODE, ST_MREQ, ST_MEVAL, ST_MEND, ST_SREQ, ST_SEVAL,
    ST_PREQ, ST_PWRITE, ST_FIN, ST_ERR, ST_ATOM, ST_ANS
  } state_t;

  state_t state_r, state_nxt;
  logic [2:0]        ncores_r, ncores_nxt;
  logic [IDX_W-1:0]  qhead_r  [CORES];
  logic [IDX_W-1:0]  qhead_nxt[CORES];
  logic [CNT_W-1:0]  qcount_r  [CORES];
  logic [CNT_W-1:0]  qcount_nxt[CORES];
  logic [63:0]       next_tag_r, next_tag_nxt;

  kind_t             kind_r, kind_nxt;
  logic [CORE_W-1:0] core_r, core_nxt;
  logic [63:0]       addr_r, addr_nxt, opv_r, opv_nxt, expv_r, expv_nxt, mem_r, mem_nxt;
  logic [1:0]        sc_r, sc_nxt;
  logic [CNT_W-1:0]  i_r, i_nxt;
  logic [CORE_W-1:0] scan_r, scan_nxt, best_core_r, best_core_nxt, pc_r, pc_nxt;
  logic              found_r, found_nxt, any_r, any_nxt;
  logic [63:0]       best_tag_r, best_tag_nxt;
  merge_t            mrg_r, mrg_nxt;

  logic              out_valid_r, out_valid_nxt, out_last_r, out_last_nxt;
  logic              out_flag_r, out_flag_nxt;
  rkind_t            out_kind_r, out_kind_nxt;
  logic [63:0]       out_addr_r, out_addr_nxt, out_data_r, out_data_nxt;
  logic [63:0]       out_sum_r, out_sum_nxt;
  logic [1:0]        out_sc_r, out_sc_nxt;

  entry_t            mem [SLOTS];
  entry_t            rd_data, wr_data;
  logic [SLOT_W-1:0] rd_addr, wr_addr;
  logic              we;

  logic [63:0]       alu_a, alu_b, sum;
  logic              alu_lt, can_emit, core_ok, cas_ok, scan_end;
  merge_t            alu_mrg;

  sbf_alu u_alu (
    .op_a    (alu_a),
    .op_b    (alu_b),
    .sc      (sc_r),
    .e_size  (rd_data.size),
    .e_value (rd_data.value),
    .cur     (mrg_r),
    .lt      (alu_lt),
    .nxt     (alu_mrg)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {5'b0, out_flag_r, out_sum_r, out_data_r, out_sc_r, out_addr_r};

  assign can_emit = !out_valid_r || out_tready;
  assign core_ok  = ({1'b0, core_r} < ncores_r);
  assign sum      = mrg_r.mval + opv_r;
  assign cas_ok   = (mrg_r.mval == expv_r);
  assign wr_addr  = {core_r, qhead_r[core_r] + qcount_r[core_r][IDX_W-1:0]};
  assign wr_data  = '{tag: next_tag_r, value: opv_r, size: sc_r, addr: addr_r};

  always_comb begin
    state_nxt      = state_r;
    ncores_nxt     = cfg_valid ? cfg_data : ncores_r;
    qhead_nxt      = qhead_r;
    qcount_nxt     = qcount_r;
    next_tag_nxt   = next_tag_r;
    kind_nxt       = kind_r;
    core_nxt       = core_r;
    addr_nxt       = addr_r;
    sc_nxt         = sc_r;
    opv_nxt        = opv_r;
    expv_nxt       = expv_r;
    mem_nxt        = mem_r;
    i_nxt          = i_r;
    scan_nxt       = scan_r;
    best_core_nxt  = best_core_r;
    best_tag_nxt   = best_tag_r;
    found_nxt      = found_r;
    any_nxt        = any_r;
    pc_nxt         = pc_r;
    mrg_nxt        = mrg_r;
    rd_addr        = '0;
    we             = 1'b0;
    alu_a          = addr_r;
    alu_b          = rd_data.addr;
    scan_end       = 1'b0;
    out_valid_nxt  = out_tready ? 1'b0 : out_valid_r;
    out_kind_nxt   = out_kind_r;
    out_addr_nxt   = out_addr_r;
    out_sc_nxt     = out_sc_r;
    out_data_nxt   = out_data_r;
    out_sum_nxt    = out_sum_r;
    out_flag_nxt   = out_flag_r;
    out_last_nxt   = out_last_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          kind_nxt  = kind_t'(in_tuser);
          core_nxt  = in_tdata[1:0];
          addr_nxt  = in_tdata[65:2];
          sc_nxt    = in_tdata[67:66];
          opv_nxt   = in_tdata[131:68];
          expv_nxt  = in_tdata[195:132];
          mem_nxt   = in_tdata[259:196];
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        any_nxt       = 1'b0;
        found_nxt     = 1'b0;
        scan_nxt      = '0;
        i_nxt         = qcount_r[core_r];
        pc_nxt        = core_r;
        mrg_nxt.mval  = mem_r & size_mask(sc_r);
        mrg_nxt.claim = '0;
        if (kind_r != K_DRAIN_OLDEST && kind_r != K_DRAIN_ALL && !core_ok) begin
          state_nxt = ST_ERR;
        end else begin
          unique case (kind_r)
            K_STORE: begin
              if (qcount_r[core_r] == CNT_W'(DEPTH)) begin
                state_nxt = ST_ERR;
              end else begin
                we                 = 1'b1;
                qcount_nxt[core_r] = qcount_r[core_r] + 1'b1;
                next_tag_nxt       = next_tag_r + 64'd1;
                state_nxt          = ST_FIN;
              end
            end
            K_LOAD, K_CAS, K_FADD:
              state_nxt = (qcount_r[core_r] != '0) ? ST_MREQ : ST_MEND;
            K_DRAIN_OLDEST, K_DRAIN_ALL:
              state_nxt = ST_SREQ;
            K_DRAIN_CORE, K_FENCE:
              state_nxt = (qcount_r[core_r] != '0) ? ST_PREQ : ST_FIN;
          endcase
        end
      end
      // Walk the core's entries from youngest to oldest; claimed bytes stick.
      ST_MREQ: begin
        rd_addr   = {core_r, qhead_r[core_r] + IDX_W'(i_r - 1'b1)};
        i_nxt     = i_r - 1'b1;
        state_nxt = ST_MEVAL;
      end
      ST_MEVAL: begin
        mrg_nxt   = alu_mrg;
        state_nxt = (i_r == '0) ? ST_MEND : ST_MREQ;
      end
      ST_MEND: begin
        if (kind_r == K_LOAD) begin
          if (can_emit) begin
            out_valid_nxt = 1'b1;
            out_kind_nxt  = RK_LOAD;
            out_addr_nxt  = '0;
            out_sc_nxt    = '0;
            out_data_nxt  = mrg_r.mval;
            out_sum_nxt   = '0;
            out_flag_nxt  = 1'b0;
            out_last_nxt  = 1'b1;
            state_nxt     = ST_IDLE;
          end
        end else begin
          pc_nxt    = core_r;
          state_nxt = (qcount_r[core_r] != '0) ? ST_PREQ : ST_ATOM;
        end
      end
      // Oldest-head scan over every core; ties keep the lower core.
      ST_SREQ: begin
        if (qcount_r[scan_r] != '0) begin
          rd_addr   = {scan_r, qhead_r[scan_r]};
          state_nxt = ST_SEVAL;
        end else begin
          scan_end = (scan_r == CORE_W'(CORES - 1));
          scan_nxt = scan_r + 1'b1;
        end
      end
      ST_SEVAL: begin
        alu_a = rd_data.tag;
        alu_b = best_tag_r;
        if (!found_r || alu_lt) begin
          found_nxt     = 1'b1;
          best_core_nxt = scan_r;
          best_tag_nxt  = rd_data.tag;
        end
        scan_end  = (scan_r == CORE_W'(CORES - 1));
        scan_nxt  = scan_r + 1'b1;
        state_nxt = ST_SREQ;
      end
      ST_PREQ: begin
        rd_addr   = {pc_r, qhead_r[pc_r]};
        state_nxt = ST_PWRITE;
      end
      ST_PWRITE: begin
        rd_addr = {pc_r, qhead_r[pc_r]};
        if (can_emit) begin
          out_valid_nxt    = 1'b1;
          out_kind_nxt     = RK_WRITE;
          out_addr_nxt     = rd_data.addr;
          out_sc_nxt       = rd_data.size;
          out_data_nxt     = rd_data.value & size_mask(rd_data.size);
          out_sum_nxt      = '0;
          out_flag_nxt     = 1'b0;
          out_last_nxt     = 1'b0;
          qhead_nxt[pc_r]  = qhead_r[pc_r] + 1'b1;
          qcount_nxt[pc_r] = qcount_r[pc_r] - 1'b1;
          any_nxt          = 1'b1;
          case (kind_r) inside
            K_DRAIN_OLDEST, K_DRAIN_CORE: state_nxt = ST_FIN;
            K_DRAIN_ALL: begin
              scan_nxt  = '0;
              found_nxt = 1'b0;
              state_nxt = ST_SREQ;
            end
            default: begin
              if (qcount_r[pc_r] != CNT_W'(1)) begin
                state_nxt = ST_PREQ;
              end else begin
                state_nxt = (kind_r == K_FENCE) ? ST_FIN : ST_ATOM;
              end
            end
          endcase
        end
      end
      ST_FIN, ST_ERR: begin
        if (can_emit) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = (state_r == ST_ERR) ? RK_ERROR : RK_DONE;
          out_addr_nxt  = '0;
          out_sc_nxt    = '0;
          out_data_nxt  = '0;
          out_sum_nxt   = '0;
          out_flag_nxt  = (state_r == ST_FIN) && any_r;
          out_last_nxt  = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_ATOM: begin
        if (kind_r == K_CAS && !cas_ok) begin
          state_nxt = ST_ANS;
        end else if (can_emit) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = RK_WRITE;
          out_addr_nxt  = addr_r;
          out_sc_nxt    = sc_r;
          out_data_nxt  = ((kind_r == K_CAS) ? opv_r : sum) & size_mask(sc_r);
          out_sum_nxt   = '0;
          out_flag_nxt  = 1'b0;
          out_last_nxt  = 1'b0;
          state_nxt     = ST_ANS;
        end
      end
      ST_ANS: begin
        if (can_emit) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = (kind_r == K_CAS) ? RK_XCHG : RK_FADD;
          out_addr_nxt  = '0;
          out_sc_nxt    = '0;
          out_data_nxt  = mrg_r.mval;
          out_sum_nxt   = (kind_r == K_CAS) ? 64'd0 : sum;
          out_flag_nxt  = (kind_r == K_CAS) && cas_ok;
          out_last_nxt  = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
    endcase

    if (scan_end) begin
      if (found_nxt) begin
        pc_nxt    = best_core_nxt;
        state_nxt = ST_PREQ;
      end else begin
        state_nxt = ST_FIN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      ncores_r     <= 3'd4;
      next_tag_r   <= '0;
      out_valid_r  <= 1'b0;
      for (int c = 0; c < CORES; c++) begin
        qhead_r[c]  <= '0;
        qcount_r[c] <= '0;
      end
    end else begin
      state_r      <= state_nxt;
      ncores_r     <= ncores_nxt;
      next_tag_r   <= next_tag_nxt;
      out_valid_r  <= out_valid_nxt;
      qhead_r      <= qhead_nxt;
      qcount_r     <= qcount_nxt;
    end
    kind_r      <= kind_nxt;
    core_r      <= core_nxt;
    addr_r      <= addr_nxt;
    sc_r        <= sc_nxt;
    opv_r       <= opv_nxt;
    expv_r      <= expv_nxt;
    mem_r       <= mem_nxt;
    i_r         <= i_nxt;
    scan_r      <= scan_nxt;
    best_core_r <= best_core_nxt;
    best_tag_r  <= best_tag_nxt;
    found_r     <= found_nxt;
    any_r       <= any_nxt;
    pc_r        <= pc_nxt;
    mrg_r       <= mrg_nxt;
    out_kind_r  <= out_kind_nxt;
    out_addr_r  <= out_addr_nxt;
    out_sc_r    <= out_sc_nxt;
    out_data_r  <= out_data_nxt;
    out_sum_r   <= out_sum_nxt;
    out_flag_r  <= out_flag_nxt;
    out_last_r  <= out_last_nxt;
  end

  // A result still waiting while the core is idle must be the final one of its request.
  a_idle_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready && out_tvalid |-> out_tlast)
    else $error("pending result while idle is not the final one");

  // Only non-empty queues are ever popped.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_PWRITE |-> qcount_r[pc_r] != '0)
    else $error("pop from an empty queue");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DECODE |-> qcount_r[core_r] <= CNT_W'(DEPTH))
    else $error("queue count beyond buffer depth");

  a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_kind_r == RK_ERROR |-> out_tlast && !out_flag_r)
    else $error("error result is not a lone final result");

endmodule
